[rtl/dnsa_pkg.sv]
// shared types and codes for the dns a-record extractor
// no dependencies; used by every module of the block
package dnsa_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned AddrW = 32;
  localparam int unsigned StatusW = 3;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_HDR     = 3'd2,
    ST_NAME    = 3'd3,
    ST_TRUNC   = 3'd4,
    ST_ALEN    = 3'd5,
    ST_NOA     = 3'd6,
    ST_PENDING = 3'd7
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             final_byte;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [AddrW-1:0]   ipv4_address;
    logic [StatusW-1:0] status;
  } out_t;

endpackage

[rtl/dnsa_in_stage.sv]
// input register for the byte stream
// depends on dnsa_pkg
module dnsa_in_stage import dnsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  input  logic adv_i,
  output logic take_o,
  output in_t  item_o
);

  logic valid_q;
  in_t  data_q;
  logic load;

  assign load       = !valid_q || adv_i;
  assign in_stall_o = !load;
  assign take_o     = valid_q && adv_i;
  assign item_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

[rtl/dnsa_parser.sv]
// per-byte parse state and verdict logic for a dns response
// depends on dnsa_pkg
module dnsa_parser import dnsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic take_i,
  input  in_t  item_i,
  output logic res_valid_o,
  output out_t res_o
);

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_NAME1  = 4'd1,
    PH_PTR2   = 4'd2,
    PH_LABEL  = 4'd3,
    PH_LABLEN = 4'd4,
    PH_QSUF   = 4'd5,
    PH_RSUF   = 4'd6,
    PH_DATA   = 4'd7,
    PH_BADA   = 4'd8,
    PH_ADDR   = 4'd9,
    PH_DONE   = 4'd10
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [5:0]       lab_q, lab_d;
  logic [15:0]      ans_q, ans_d;
  logic [15:0]      rtype_q, rtype_d;
  logic [15:0]      dlen_q, dlen_d;
  logic [AddrW-1:0] addr_q, addr_d;
  status_e          verdict_q, verdict_d;
  logic             hdr_bad_q, hdr_bad_d;
  logic             in_ans_q, in_ans_d;
  logic [ByteW-1:0] b;
  status_e          st;

  assign b = item_i.data_byte;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    lab_d     = lab_q;
    ans_d     = ans_q;
    rtype_d   = rtype_q;
    dlen_d    = dlen_q;
    addr_d    = addr_q;
    verdict_d = verdict_q;
    hdr_bad_d = hdr_bad_q;
    in_ans_d  = in_ans_q;
    st        = ST_PENDING;
    if (take_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (cnt_q == 4'd2 && !b[7]) hdr_bad_d = 1'b1;
          if (cnt_q == 4'd4 && b != 8'd0) hdr_bad_d = 1'b1;
          if (cnt_q == 4'd5 && b != 8'd1) hdr_bad_d = 1'b1;
          if (cnt_q == 4'd6) ans_d = {b, 8'h00};
          if (cnt_q == 4'd7) ans_d = {ans_q[15:8], b};
          if (cnt_q == 4'd11) begin
            cnt_d = 4'd0;
            if (hdr_bad_d) begin
              verdict_d = ST_HDR;
              phase_d   = PH_DONE;
            end else begin
              phase_d = PH_NAME1;
            end
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
        PH_NAME1: begin
          if (b == 8'd0) begin
            cnt_d   = 4'd0;
            phase_d = in_ans_q ? PH_RSUF : PH_QSUF;
          end else if (b[7:6] == 2'b11) begin
            phase_d = PH_PTR2;
          end else if (b[7:6] != 2'b00) begin
            verdict_d = ST_NAME;
            phase_d   = PH_DONE;
          end else begin
            lab_d   = b[5:0];
            phase_d = PH_LABEL;
          end
        end
        PH_PTR2: begin
          cnt_d   = 4'd0;
          phase_d = in_ans_q ? PH_RSUF : PH_QSUF;
        end
        PH_LABEL: begin
          lab_d = lab_q - 6'd1;
          if (lab_q == 6'd1) phase_d = PH_LABLEN;
        end
        PH_LABLEN: begin
          if (b == 8'd0) begin
            cnt_d   = 4'd0;
            phase_d = in_ans_q ? PH_RSUF : PH_QSUF;
          end else if (b[7:6] != 2'b00) begin
            verdict_d = ST_NAME;
            phase_d   = PH_DONE;
          end else begin
            lab_d   = b[5:0];
            phase_d = PH_LABEL;
          end
        end
        PH_QSUF: begin
          cnt_d = cnt_q + 4'd1;
          if (cnt_q == 4'd3) begin
            in_ans_d = 1'b1;
            if (ans_q == 16'd0) begin
              verdict_d = ST_NOA;
              phase_d   = PH_DONE;
            end else begin
              phase_d = PH_NAME1;
            end
          end
        end
        PH_RSUF: begin
          if (cnt_q == 4'd0) rtype_d = {b, 8'h00};
          if (cnt_q == 4'd1) rtype_d = {rtype_q[15:8], b};
          if (cnt_q == 4'd8) dlen_d = {b, 8'h00};
          if (cnt_q == 4'd9) dlen_d = {dlen_q[15:8], b};
          if (cnt_q == 4'd9) begin
            cnt_d = 4'd0;
            if (rtype_q == 16'd1) begin
              if (dlen_d == 16'd4) begin
                addr_d  = '0;
                phase_d = PH_ADDR;
              end else if (dlen_d == 16'd0) begin
                verdict_d = ST_ALEN;
                phase_d   = PH_DONE;
              end else begin
                phase_d = PH_BADA;
              end
            end else if (dlen_d == 16'd0) begin
              ans_d = ans_q - 16'd1;
              if (ans_q == 16'd1) begin
                verdict_d = ST_NOA;
                phase_d   = PH_DONE;
              end else begin
                phase_d = PH_NAME1;
              end
            end else begin
              phase_d = PH_DATA;
            end
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
        PH_DATA: begin
          dlen_d = dlen_q - 16'd1;
          if (dlen_q == 16'd1) begin
            ans_d = ans_q - 16'd1;
            if (ans_q == 16'd1) begin
              verdict_d = ST_NOA;
              phase_d   = PH_DONE;
            end else begin
              phase_d = PH_NAME1;
            end
          end
        end
        PH_BADA: begin
          dlen_d = dlen_q - 16'd1;
          if (dlen_q == 16'd1) begin
            verdict_d = ST_ALEN;
            phase_d   = PH_DONE;
          end
        end
        PH_ADDR: begin
          addr_d = {addr_q[AddrW-ByteW-1:0], b};
          cnt_d  = cnt_q + 4'd1;
          if (cnt_q == 4'd3) begin
            verdict_d = ST_OK;
            phase_d   = PH_DONE;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      if (item_i.final_byte) begin
        if (verdict_d == ST_PENDING) begin
          st = (phase_d == PH_HEADER) ? ST_SHORT : ST_TRUNC;
        end else begin
          st = verdict_d;
        end
        // back to a clean state for the next datagram
        phase_d   = PH_HEADER;
        cnt_d     = 4'd0;
        lab_d     = 6'd0;
        ans_d     = 16'd0;
        rtype_d   = 16'd0;
        dlen_d    = 16'd0;
        verdict_d = ST_PENDING;
        hdr_bad_d = 1'b0;
        in_ans_d  = 1'b0;
      end
    end
  end

  assign res_valid_o        = take_i && item_i.final_byte;
  assign res_o.found        = (st == ST_OK);
  assign res_o.ipv4_address = (st == ST_OK) ? addr_d : '1;
  assign res_o.status       = st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      cnt_q     <= 4'd0;
      lab_q     <= 6'd0;
      ans_q     <= 16'd0;
      rtype_q   <= 16'd0;
      dlen_q    <= 16'd0;
      addr_q    <= '0;
      verdict_q <= ST_PENDING;
      hdr_bad_q <= 1'b0;
      in_ans_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      lab_q     <= lab_d;
      ans_q     <= ans_d;
      rtype_q   <= rtype_d;
      dlen_q    <= dlen_d;
      addr_q    <= addr_d;
      verdict_q <= verdict_d;
      hdr_bad_q <= hdr_bad_d;
      in_ans_q  <= in_ans_d;
    end
  end

  a_done_iff_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) == (verdict_q != ST_PENDING))
    else $error("done phase and verdict disagree");

  a_label_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LABEL) |-> (lab_q != 6'd0))
    else $error("label phase with empty label count");

  a_addr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ADDR) |-> (cnt_q < 4'd4))
    else $error("address byte count out of range");

  a_final_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (phase_q == PH_HEADER && cnt_q == 4'd0 && !in_ans_q))
    else $error("state not cleared after last byte");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.found == (res_o.status == ST_OK)) && (res_o.status != ST_PENDING))
    else $error("result found flag and status disagree");

endmodule

[rtl/dnsa_out_stage.sv]
// result register between the parser and the output channel
// depends on dnsa_pkg
module dnsa_out_stage import dnsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  input  out_t res_i,
  output logic adv_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic valid_q;
  out_t data_q;

  assign adv_o       = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule

[rtl/dns_response_a_record_extractor_unit.sv]
// a result is valid once its last byte has passed the input register and then the result register (two registers)
// throughput: one byte per cycle; input stalls only while a held result sees out_stall_i
// reset: asynchronous, active low; parse state returns to the header phase, both registers empty
// top level of the dns response a-record extractor
// depends on dnsa_pkg, dnsa_in_stage, dnsa_parser, dnsa_out_stage
module dns_response_a_record_extractor_unit import dnsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic adv;
  logic take;
  in_t  item;
  logic res_valid;
  out_t res;

  dnsa_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .adv_i      (adv),
    .take_o     (take),
    .item_o     (item)
  );

  dnsa_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dnsa_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
